// File: design/fbn_pkg.sv
package fbn_pkg;

    // Configuration registers as seen by the engine.
    typedef struct packed {
        logic [47:0] server_mac;
        logic [15:0] reply_delay;
        logic [15:0] send_delay;
    } cfg_t;

    // One input item, first field in the highest bits.
    typedef struct packed {
        logic [7:0] write_byte;
        logic [3:0] reg_index;
        logic [1:0] action;
    } item_t;

    // One result item, first field in the highest bits.
    typedef struct packed {
        logic       reply_delivered;
        logic       frame_sent;
        logic [7:0] read_byte;
    } res_t;

    localparam int ITEM_W = 14;
    localparam int RES_W  = 10;
    localparam int TDATA_W = 16;

    // Actions.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Device register indexes.
    localparam logic [3:0] REG_RX_PTR_LO = 4'd0;
    localparam logic [3:0] REG_RX_PTR_HI = 4'd1;
    localparam logic [3:0] REG_RX_DATA   = 4'd2;
    localparam logic [3:0] REG_RX_OWN    = 4'd3;
    localparam logic [3:0] REG_TX_PTR_LO = 4'd8;
    localparam logic [3:0] REG_TX_PTR_HI = 4'd9;
    localparam logic [3:0] REG_TX_DATA   = 4'd10;
    localparam logic [3:0] REG_TX_OWN    = 4'd11;

    // Configuration register indexes and reset values.
    localparam int CFG_ADDR_W = 5;
    localparam logic [1:0] CFG_SEND_DELAY  = 2'd0;
    localparam logic [1:0] CFG_REPLY_DELAY = 2'd1;
    localparam logic [1:0] CFG_SERVER_MAC  = 2'd2;
    localparam logic [15:0] SEND_DELAY_RST  = 16'd200;
    localparam logic [15:0] REPLY_DELAY_RST = 16'd200;
    localparam logic [47:0] SERVER_MAC_RST  = 48'h0011_2233_4455;

    // ARP frame layout; offsets count from the start of the buffer.
    localparam logic [7:0] ARP_TYPE_HI   = 8'h08;
    localparam logic [7:0] ARP_TYPE_LO   = 8'h06;
    localparam logic [7:0] ARP_OP_HI     = 8'h00;
    localparam logic [7:0] ARP_OP_REQ_LO = 8'h01;
    localparam logic [7:0] ARP_OP_REP_LO = 8'h02;
    localparam logic [5:0] OFS_TYPE_HI   = 6'd14;
    localparam logic [5:0] OFS_TYPE_LO   = 6'd15;
    localparam logic [5:0] OFS_OP_HI     = 6'd22;
    localparam logic [5:0] OFS_OP_LO     = 6'd23;

    // The four bytes that identify an ARP request, in the order they are read.
    function automatic logic [5:0] check_offset(input logic [1:0] idx);
        logic [5:0] ofs;
        case (idx)
            2'd0:    ofs = OFS_TYPE_HI;
            2'd1:    ofs = OFS_TYPE_LO;
            2'd2:    ofs = OFS_OP_HI;
            default: ofs = OFS_OP_LO;
        endcase
        return ofs;
    endfunction

    function automatic logic [7:0] check_expect(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = ARP_TYPE_HI;
            2'd1:    val = ARP_TYPE_LO;
            2'd2:    val = ARP_OP_HI;
            default: val = ARP_OP_REQ_LO;
        endcase
        return val;
    endfunction

    // Transmit offset that feeds a given reply offset: the sender protocol
    // address comes from the target's, the target addresses from the sender's.
    function automatic logic [15:0] reply_source(input logic [15:0] ofs);
        logic [15:0] src;
        if (ofs inside {[16'd30:16'd33]}) begin
            src = ofs + 16'd10;
        end
        else if (ofs inside {[16'd34:16'd43]}) begin
            src = ofs - 16'd10;
        end
        else begin
            src = ofs;
        end
        return src;
    endfunction

endpackage

// File: design/fbn_ram.sv
module fbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/fbn_cfg.sv
module fbn_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fbn_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    output fbn_pkg::cfg_t                   cfg
);

    logic [15:0] send_delay_reg;
    logic [15:0] reply_delay_reg;
    logic [47:0] server_mac_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_delay_reg  <= fbn_pkg::SEND_DELAY_RST;
            reply_delay_reg <= fbn_pkg::REPLY_DELAY_RST;
            server_mac_reg  <= fbn_pkg::SERVER_MAC_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                fbn_pkg::CFG_SEND_DELAY:  send_delay_reg  <= pwdata[15:0];
                fbn_pkg::CFG_REPLY_DELAY: reply_delay_reg <= pwdata[15:0];
                fbn_pkg::CFG_SERVER_MAC:  server_mac_reg  <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            fbn_pkg::CFG_SEND_DELAY:  prdata = {48'd0, send_delay_reg};
            fbn_pkg::CFG_REPLY_DELAY: prdata = {48'd0, reply_delay_reg};
            fbn_pkg::CFG_SERVER_MAC:  prdata = {16'd0, server_mac_reg};
            default:                  prdata = 64'd0;
        endcase
    end

    assign cfg.send_delay  = send_delay_reg;
    assign cfg.reply_delay = reply_delay_reg;
    assign cfg.server_mac  = server_mac_reg;

endmodule

// File: design/fbn_engine.sv
module fbn_engine #(
    parameter int BUF_DEPTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbn_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fbn_pkg::TDATA_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fbn_pkg::TDATA_W-1:0]   m_tdata
);

    localparam int AW = $clog2(BUF_DEPTH);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_RDWAIT  = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_BUILD   = 3'd4;
    localparam logic [2:0] ST_RXSTEP  = 3'd5;
    localparam logic [2:0] ST_DELIVER = 3'd6;
    localparam logic [2:0] ST_WAIT    = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       rx_ptr_reg, rx_ptr_next;
    logic [AW-1:0]       tx_ptr_reg, tx_ptr_next;
    logic                rx_own_reg, rx_own_next;
    logic                tx_own_reg, tx_own_next;
    logic [15:0]         send_cd_reg, send_cd_next;
    logic [15:0]         reply_cd_reg, reply_cd_next;
    logic                pending_reg, pending_next;
    logic [AW:0]         cnt_reg, cnt_next;
    logic                wv_reg, wv_next;
    logic [AW-1:0]       wa_reg, wa_next;
    logic                match_reg, match_next;
    logic                rd_tx_reg, rd_tx_next;
    logic                sent_reg, sent_next;
    fbn_pkg::res_t       hold_reg, hold_next;
    logic                out_valid_reg, out_valid_next;
    fbn_pkg::res_t       out_data_reg, out_data_next;

    logic                rx_we, tx_we, rp_we;
    logic [AW-1:0]       rx_waddr, tx_waddr, rp_waddr;
    logic [7:0]          rx_wdata, tx_wdata, rp_wdata;
    logic [AW-1:0]       rx_raddr, tx_raddr, rp_raddr;
    logic [7:0]          rx_rdata, tx_rdata, rp_rdata;

    fbn_pkg::item_t      item;
    fbn_pkg::res_t       fin;
    logic                fin_v;
    logic                acc;
    logic                out_free;
    logic [15:0]         rx_ptr16, tx_ptr16;
    logic                rx_deliver_go, rx_dec;
    logic                copy_issue, copy_done;
    logic                check_issue, check_ok;

    // Reply byte at a given offset: operation and sender MAC are replaced,
    // everything else is the transmit byte fetched from reply_source().
    function automatic logic [7:0] reply_byte(input logic [15:0] ofs,
                                              input logic [7:0]  data,
                                              input logic [47:0] mac);
        logic [7:0] b;
        case (ofs)
            16'd22:  b = fbn_pkg::ARP_OP_HI;
            16'd23:  b = fbn_pkg::ARP_OP_REP_LO;
            16'd24:  b = mac[47:40];
            16'd25:  b = mac[39:32];
            16'd26:  b = mac[31:24];
            16'd27:  b = mac[23:16];
            16'd28:  b = mac[15:8];
            16'd29:  b = mac[7:0];
            default: b = data;
        endcase
        return b;
    endfunction

    fbn_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    fbn_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    fbn_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_reply_ram (
        .clk   (clk),
        .we    (rp_we),
        .waddr (rp_waddr),
        .wdata (rp_wdata),
        .raddr (rp_raddr),
        .rdata (rp_rdata)
    );

    assign item     = fbn_pkg::item_t'(s_tdata[fbn_pkg::ITEM_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rx_ptr16 = 16'(rx_ptr_reg);
    assign tx_ptr16 = 16'(tx_ptr_reg);

    assign rx_deliver_go = rx_own_reg && (reply_cd_reg == 16'd0) && pending_reg;
    assign rx_dec        = rx_own_reg && (reply_cd_reg != 16'd0);

    // Copies issue one read per cycle; each write follows in the cycle after its read.
    assign copy_issue  = !cnt_reg[AW];
    assign copy_done   = wv_reg && !copy_issue;
    assign check_issue = !cnt_reg[2];
    assign check_ok    = match_reg && (tx_rdata == fbn_pkg::check_expect(wa_reg[1:0]));

    always_comb
    begin
        state_next     = state_reg;
        rx_ptr_next    = rx_ptr_reg;
        tx_ptr_next    = tx_ptr_reg;
        rx_own_next    = rx_own_reg;
        tx_own_next    = tx_own_reg;
        send_cd_next   = send_cd_reg;
        reply_cd_next  = reply_cd_reg;
        pending_next   = pending_reg;
        cnt_next       = cnt_reg;
        wv_next        = 1'b0;
        wa_next        = wa_reg;
        match_next     = match_reg;
        rd_tx_next     = rd_tx_reg;
        sent_next      = sent_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        rx_we    = 1'b0;
        rx_waddr = rx_ptr_reg;
        rx_wdata = item.write_byte;
        rx_raddr = rx_ptr_reg;
        tx_we    = 1'b0;
        tx_waddr = tx_ptr_reg;
        tx_wdata = item.write_byte;
        tx_raddr = tx_ptr_reg;
        rp_we    = 1'b0;
        rp_waddr = wa_reg;
        rp_wdata = 8'd0;
        rp_raddr = cnt_reg[AW-1:0];

        fin_v = 1'b0;
        fin   = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                rx_we    = 1'b1;
                tx_we    = 1'b1;
                rp_we    = 1'b1;
                rx_waddr = cnt_reg[AW-1:0];
                tx_waddr = cnt_reg[AW-1:0];
                rp_waddr = cnt_reg[AW-1:0];
                rx_wdata = 8'd0;
                tx_wdata = 8'd0;
                rp_wdata = 8'd0;
                if (cnt_reg[AW-1:0] == '1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + (AW+1)'(1);
                end
            end

            ST_IDLE:
            begin
                if (acc)
                begin
                    case (item.action)
                        fbn_pkg::ACT_READ:
                        begin
                            case (item.reg_index)
                                fbn_pkg::REG_RX_PTR_LO:
                                begin
                                    fin_v = 1'b1;
                                    fin.read_byte = rx_ptr16[7:0];
                                end
                                fbn_pkg::REG_RX_PTR_HI:
                                begin
                                    fin_v = 1'b1;
                                    fin.read_byte = rx_ptr16[15:8];
                                end
                                fbn_pkg::REG_RX_DATA:
                                begin
                                    rx_ptr_next = rx_ptr_reg + AW'(1);
                                    rd_tx_next  = 1'b0;
                                    state_next  = ST_RDWAIT;
                                end
                                fbn_pkg::REG_RX_OWN:
                                begin
                                    fin_v = 1'b1;
                                    fin.read_byte = {7'd0, rx_own_reg};
                                end
                                fbn_pkg::REG_TX_PTR_LO:
                                begin
                                    fin_v = 1'b1;
                                    fin.read_byte = tx_ptr16[7:0];
                                end
                                fbn_pkg::REG_TX_PTR_HI:
                                begin
                                    fin_v = 1'b1;
                                    fin.read_byte = tx_ptr16[15:8];
                                end
                                fbn_pkg::REG_TX_DATA:
                                begin
                                    tx_ptr_next = tx_ptr_reg + AW'(1);
                                    rd_tx_next  = 1'b1;
                                    state_next  = ST_RDWAIT;
                                end
                                fbn_pkg::REG_TX_OWN:
                                begin
                                    fin_v = 1'b1;
                                    fin.read_byte = {7'd0, tx_own_reg};
                                end
                                default:
                                begin
                                    fin_v = 1'b1;
                                end
                            endcase
                        end

                        fbn_pkg::ACT_WRITE:
                        begin
                            fin_v = 1'b1;
                            case (item.reg_index)
                                fbn_pkg::REG_RX_PTR_LO:
                                    rx_ptr_next = AW'({rx_ptr16[15:8], item.write_byte});
                                fbn_pkg::REG_RX_PTR_HI:
                                    rx_ptr_next = AW'({item.write_byte, rx_ptr16[7:0]});
                                fbn_pkg::REG_RX_DATA:
                                begin
                                    rx_we       = 1'b1;
                                    rx_ptr_next = rx_ptr_reg + AW'(1);
                                end
                                fbn_pkg::REG_RX_OWN:
                                begin
                                    if (item.write_byte[0])
                                    begin
                                        rx_own_next = 1'b1;
                                    end
                                end
                                fbn_pkg::REG_TX_PTR_LO:
                                    tx_ptr_next = AW'({tx_ptr16[15:8], item.write_byte});
                                fbn_pkg::REG_TX_PTR_HI:
                                    tx_ptr_next = AW'({item.write_byte, tx_ptr16[7:0]});
                                fbn_pkg::REG_TX_DATA:
                                begin
                                    tx_we       = 1'b1;
                                    tx_ptr_next = tx_ptr_reg + AW'(1);
                                end
                                fbn_pkg::REG_TX_OWN:
                                begin
                                    if (!tx_own_reg && item.write_byte[0])
                                    begin
                                        tx_own_next  = 1'b1;
                                        send_cd_next = cfg.send_delay;
                                    end
                                end
                                default: ;
                            endcase
                        end

                        fbn_pkg::ACT_TICK:
                        begin
                            if (tx_own_reg && (send_cd_reg == 16'd0))
                            begin
                                cnt_next   = '0;
                                match_next = 1'b1;
                                state_next = ST_CHECK;
                            end
                            else
                            begin
                                if (tx_own_reg)
                                begin
                                    send_cd_next = send_cd_reg - 16'd1;
                                end
                                if (rx_deliver_go)
                                begin
                                    cnt_next   = '0;
                                    sent_next  = 1'b0;
                                    state_next = ST_DELIVER;
                                end
                                else
                                begin
                                    if (rx_dec)
                                    begin
                                        reply_cd_next = reply_cd_reg - 16'd1;
                                    end
                                    fin_v = 1'b1;
                                end
                            end
                        end

                        default:
                        begin
                            fin_v = 1'b1;
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                fin_v = 1'b1;
                fin.read_byte = rd_tx_reg ? tx_rdata : rx_rdata;
            end

            ST_CHECK:
            begin
                tx_raddr = AW'(fbn_pkg::check_offset(cnt_reg[1:0]));
                wv_next  = check_issue;
                wa_next  = cnt_reg[AW-1:0];
                if (check_issue)
                begin
                    cnt_next = cnt_reg + (AW+1)'(1);
                end
                if (wv_reg && check_issue)
                begin
                    match_next = check_ok;
                end
                if (wv_reg && !check_issue)
                begin
                    cnt_next = '0;
                    if (check_ok)
                    begin
                        state_next = ST_BUILD;
                    end
                    else
                    begin
                        tx_own_next = 1'b0;
                        state_next  = ST_RXSTEP;
                    end
                end
            end

            ST_BUILD:
            begin
                tx_raddr = AW'(fbn_pkg::reply_source(16'(cnt_reg[AW-1:0])));
                wv_next  = copy_issue;
                wa_next  = cnt_reg[AW-1:0];
                rp_we    = wv_reg;
                rp_waddr = wa_reg;
                rp_wdata = reply_byte(16'(wa_reg), tx_rdata, cfg.server_mac);
                if (copy_issue)
                begin
                    cnt_next = cnt_reg + (AW+1)'(1);
                end
                if (copy_done)
                begin
                    pending_next  = 1'b1;
                    reply_cd_next = cfg.reply_delay;
                    tx_own_next   = 1'b0;
                    state_next    = ST_RXSTEP;
                end
            end

            ST_RXSTEP:
            begin
                if (rx_deliver_go)
                begin
                    cnt_next   = '0;
                    sent_next  = 1'b1;
                    state_next = ST_DELIVER;
                end
                else
                begin
                    if (rx_dec)
                    begin
                        reply_cd_next = reply_cd_reg - 16'd1;
                    end
                    fin_v = 1'b1;
                    fin.frame_sent = 1'b1;
                end
            end

            ST_DELIVER:
            begin
                rp_raddr = cnt_reg[AW-1:0];
                wv_next  = copy_issue;
                wa_next  = cnt_reg[AW-1:0];
                rx_we    = wv_reg;
                rx_waddr = wa_reg;
                rx_wdata = rp_rdata;
                if (copy_issue)
                begin
                    cnt_next = cnt_reg + (AW+1)'(1);
                end
                if (copy_done)
                begin
                    rx_own_next  = 1'b0;
                    pending_next = 1'b0;
                    fin_v = 1'b1;
                    fin.frame_sent      = sent_reg;
                    fin.reply_delivered = 1'b1;
                end
            end

            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = hold_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished item goes straight to the output register when it is
        // free, else it parks in the hold register until the sink drains.
        if (fin_v)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fin;
                state_next     = ST_IDLE;
            end
            else
            begin
                hold_next  = fin;
                state_next = ST_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rx_ptr_reg    <= '0;
            tx_ptr_reg    <= '0;
            rx_own_reg    <= 1'b0;
            tx_own_reg    <= 1'b0;
            send_cd_reg   <= 16'd0;
            reply_cd_reg  <= 16'd0;
            pending_reg   <= 1'b0;
            cnt_reg       <= '0;
            wv_reg        <= 1'b0;
            match_reg     <= 1'b0;
            rd_tx_reg     <= 1'b0;
            sent_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rx_ptr_reg    <= rx_ptr_next;
            tx_ptr_reg    <= tx_ptr_next;
            rx_own_reg    <= rx_own_next;
            tx_own_reg    <= tx_own_next;
            send_cd_reg   <= send_cd_next;
            reply_cd_reg  <= reply_cd_next;
            pending_reg   <= pending_next;
            cnt_reg       <= cnt_next;
            wv_reg        <= wv_next;
            match_reg     <= match_next;
            rd_tx_reg     <= rd_tx_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg       <= wa_next;
        hold_reg     <= hold_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fbn_pkg::TDATA_W-fbn_pkg::RES_W){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    a_wait_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> out_valid_reg)
        else $error("hold state entered with an empty output register");

    a_deliver_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER) |-> (rx_own_reg && pending_reg))
        else $error("reply copy runs without receive ownership or a pending reply");

    a_send_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK || state_reg == ST_BUILD) |-> tx_own_reg)
        else $error("frame send runs without transmit ownership");

    a_deliver_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DELIVER && copy_done) |=> (!rx_own_reg && !pending_reg))
        else $error("receive ownership kept after a reply was delivered");
`endif

endmodule

// File: design/frame_buffer_nic_with_arp_reply_core.sv
// Frame-buffer network device with ARP reply generation.
// Items arrive on the s_axis channel: each is a register read, a register
// write or one clock tick of the emulated device. Every item yields exactly
// one result item on the m_axis channel carrying the read data and the
// frame-sent and reply-delivered flags. Send and reply delays and the
// server MAC are set through the APB port; the user must write them only
// while the block is idle, as the block itself does not enforce this.
// Pointer and ownership accesses, data writes and plain ticks finish when
// accepted; data reads also wait for the buffer memory read. A tick that
// sends a frame first reads back the four type and operation bytes and,
// for an ARP request, copies the reply byte by byte through the transmit
// memory read port into the reply buffer; a tick that delivers a reply
// copies it from the reply buffer into the receive buffer. After reset
// the three buffers are zeroed in a clearing pass during which s_axis_tready
// stays low; APB writes are taken throughout. A stalled m_axis sink holds
// the result in the output register; one more item is accepted and parked,
// after which s_axis_tready drops until the output register drains.
module frame_buffer_nic_with_arp_reply_core #(
    parameter int BUF_DEPTH = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port: send_delay at 0, reply_delay at 8,
    // server_mac at 16.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbn_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready,
    // Input items.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // action[1:0], reg_index[5:2],
                                                          // write_byte[13:6]
    // Result items.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata   // read_byte[7:0], frame_sent[8],
                                                          // reply_delivered[9]
);

    fbn_pkg::cfg_t cfg;

    // Configuration registers are read live by the engine; they must only be
    // written while no item is in flight, which the block does not enforce.
    fbn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The engine owns the three buffer memories and sequences every access
    // to them, including the reset clearing pass and the frame copies.
    fbn_engine #(.BUF_DEPTH(BUF_DEPTH)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

endmodule

// File: tb/tb_frame_buffer_nic_with_arp_reply_core.sv
`timescale 1ns / 100ps

module tb_frame_buffer_nic_with_arp_reply_core;

    localparam int NIC_DEPTH = 2048;
    localparam int PTR_W     = $clog2(NIC_DEPTH);

    // Action code three is unused by the device, and register twelve is one
    // of the inert indexes.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [3:0] REG_SPARE  = 4'd12;

    // Byte offsets of the ARP address fields inside a buffer.
    localparam int SHA_OFS = 24;
    localparam int SPA_OFS = 30;
    localparam int THA_OFS = 34;
    localparam int TPA_OFS = 40;

    localparam int MAX_SHOWN = 10;

    // Items in the random part of the run.
    localparam int RAND_ITEMS = 450;

    // Shadow copy of the device. Every accepted item is applied here, and the
    // result that the device must return for it is queued in arrival order.
    class nic_scoreboard;
        logic [7:0]       rx_buf    [NIC_DEPTH];
        logic [7:0]       tx_buf    [NIC_DEPTH];
        logic [7:0]       reply_buf [NIC_DEPTH];
        logic [PTR_W-1:0] rx_ptr;
        logic [PTR_W-1:0] tx_ptr;
        bit               rx_owned;
        bit               tx_owned;
        bit               reply_pending;
        logic [15:0]      send_count;
        logic [15:0]      reply_count;
        logic [15:0]      send_delay;
        logic [15:0]      reply_delay;
        logic [47:0]      server_mac;
        fbn_pkg::res_t    response_q [$];
        int unsigned      errors;

        function new();
            foreach (rx_buf[i])
            begin
                rx_buf[i]    = 8'h00;
                tx_buf[i]    = 8'h00;
                reply_buf[i] = 8'h00;
            end
            rx_ptr        = '0;
            tx_ptr        = '0;
            rx_owned      = 1'b0;
            tx_owned      = 1'b0;
            reply_pending = 1'b0;
            send_count    = '0;
            reply_count   = '0;
            send_delay    = fbn_pkg::SEND_DELAY_RST;
            reply_delay   = fbn_pkg::REPLY_DELAY_RST;
            server_mac    = fbn_pkg::SERVER_MAC_RST;
            errors        = 0;
        endfunction

        function int outstanding();
            return response_q.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("[%0t] MISMATCH %s", $time, msg);
        endfunction

        function void set_cfg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                fbn_pkg::CFG_SEND_DELAY:  send_delay  = val[15:0];
                fbn_pkg::CFG_REPLY_DELAY: reply_delay = val[15:0];
                fbn_pkg::CFG_SERVER_MAC:  server_mac  = val[47:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] cfg_value(logic [1:0] idx);
            case (idx)
                fbn_pkg::CFG_SEND_DELAY:  return {48'h0, send_delay};
                fbn_pkg::CFG_REPLY_DELAY: return {48'h0, reply_delay};
                default:                  return {16'h0, server_mac};
            endcase
        endfunction

        // Applies one item to the shadow state and queues the result it causes.
        function void note_item(fbn_pkg::item_t it);
            fbn_pkg::res_t r;
            int            i;
            r = '0;
            case (it.action)
                fbn_pkg::ACT_READ:
                begin
                    case (it.reg_index)
                        fbn_pkg::REG_RX_PTR_LO: r.read_byte = rx_ptr[7:0];
                        fbn_pkg::REG_RX_PTR_HI: r.read_byte = 8'(rx_ptr >> 8);
                        fbn_pkg::REG_RX_DATA:
                        begin
                            r.read_byte = rx_buf[rx_ptr];
                            rx_ptr++;
                        end
                        fbn_pkg::REG_RX_OWN:    r.read_byte = {7'b0, rx_owned};
                        fbn_pkg::REG_TX_PTR_LO: r.read_byte = tx_ptr[7:0];
                        fbn_pkg::REG_TX_PTR_HI: r.read_byte = 8'(tx_ptr >> 8);
                        fbn_pkg::REG_TX_DATA:
                        begin
                            r.read_byte = tx_buf[tx_ptr];
                            tx_ptr++;
                        end
                        fbn_pkg::REG_TX_OWN:    r.read_byte = {7'b0, tx_owned};
                        default: ;
                    endcase
                end
                fbn_pkg::ACT_WRITE:
                begin
                    case (it.reg_index)
                        fbn_pkg::REG_RX_PTR_LO: rx_ptr[7:0] = it.write_byte;
                        fbn_pkg::REG_RX_PTR_HI:
                            rx_ptr = PTR_W'({it.write_byte, rx_ptr[7:0]});
                        fbn_pkg::REG_RX_DATA:
                        begin
                            rx_buf[rx_ptr] = it.write_byte;
                            rx_ptr++;
                        end
                        fbn_pkg::REG_RX_OWN:
                        begin
                            if (it.write_byte[0])
                                rx_owned = 1'b1;
                        end
                        fbn_pkg::REG_TX_PTR_LO: tx_ptr[7:0] = it.write_byte;
                        fbn_pkg::REG_TX_PTR_HI:
                            tx_ptr = PTR_W'({it.write_byte, tx_ptr[7:0]});
                        fbn_pkg::REG_TX_DATA:
                        begin
                            tx_buf[tx_ptr] = it.write_byte;
                            tx_ptr++;
                        end
                        fbn_pkg::REG_TX_OWN:
                        begin
                            if (!tx_owned && it.write_byte[0])
                            begin
                                tx_owned   = 1'b1;
                                send_count = send_delay;
                            end
                        end
                        default: ;
                    endcase
                end
                fbn_pkg::ACT_TICK:
                begin
                    // Transmit goes first, so a fresh reply can be delivered
                    // in the same tick when its delay is zero.
                    if (tx_owned)
                    begin
                        if (send_count == 0)
                        begin
                            if (tx_buf[fbn_pkg::OFS_TYPE_HI] == fbn_pkg::ARP_TYPE_HI &&
                                tx_buf[fbn_pkg::OFS_TYPE_LO] == fbn_pkg::ARP_TYPE_LO &&
                                tx_buf[fbn_pkg::OFS_OP_HI] == fbn_pkg::ARP_OP_HI &&
                                tx_buf[fbn_pkg::OFS_OP_LO] == fbn_pkg::ARP_OP_REQ_LO)
                            begin
                                reply_buf = tx_buf;
                                reply_buf[fbn_pkg::OFS_OP_HI] = fbn_pkg::ARP_OP_HI;
                                reply_buf[fbn_pkg::OFS_OP_LO] = fbn_pkg::ARP_OP_REP_LO;
                                for (i = 0; i < 10; i++)
                                    reply_buf[THA_OFS + i] = tx_buf[SHA_OFS + i];
                                for (i = 0; i < 4; i++)
                                    reply_buf[SPA_OFS + i] = tx_buf[TPA_OFS + i];
                                for (i = 0; i < 6; i++)
                                    reply_buf[SHA_OFS + i] = server_mac[47 - 8 * i -: 8];
                                reply_pending = 1'b1;
                                reply_count   = reply_delay;
                            end
                            tx_owned     = 1'b0;
                            r.frame_sent = 1'b1;
                        end
                        else
                        begin
                            send_count--;
                        end
                    end
                    if (rx_owned)
                    begin
                        if (reply_count == 0)
                        begin
                            if (reply_pending)
                            begin
                                rx_buf            = reply_buf;
                                rx_owned          = 1'b0;
                                reply_pending     = 1'b0;
                                r.reply_delivered = 1'b1;
                            end
                        end
                        else
                        begin
                            reply_count--;
                        end
                    end
                end
                default: ;
            endcase
            response_q.push_back(r);
        endfunction

        function void check_result(fbn_pkg::res_t got);
            fbn_pkg::res_t want;
            if (response_q.size() == 0)
            begin
                flag($sformatf("result %h arrived with nothing outstanding", got));
                return;
            end
            want = response_q.pop_front();
            if (got.read_byte !== want.read_byte ||
                got.frame_sent !== want.frame_sent ||
                got.reply_delivered !== want.reply_delivered)
                flag($sformatf({"read_byte exp %h got %h, frame_sent exp %b got %b, ",
                                "reply_delivered exp %b got %b"},
                               want.read_byte, got.read_byte,
                               want.frame_sent, got.frame_sent,
                               want.reply_delivered, got.reply_delivered));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [fbn_pkg::CFG_ADDR_W-1:0] paddr;
    logic [63:0]                    pwdata;
    logic [63:0]                    prdata;
    logic                           pready;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;   // action[1:0], reg_index[5:2],
                                                    // write_byte[13:6]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [15:0]                    m_axis_tdata;   // read_byte[7:0], frame_sent[8],
                                                    // reply_delivered[9]

    nic_scoreboard sb;

    // While this is set, neither side inserts gaps, so the block is exercised
    // back to back.
    bit quiet;
    int unsigned items_sent;

    frame_buffer_nic_with_arp_reply_core #(
        .BUF_DEPTH(NIC_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs somewhere; the limit lies well beyond
    // the slowest legal run.
    initial
    begin
        #(20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    // Gap lengths for both sides: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Result sink. Outputs are sampled at the rising edge; tready moves only
    // at the falling edge.
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0 && !quiet)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                hold = 0;
                if (!quiet && $urandom_range(99) < 20)
                    hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(fbn_pkg::res_t'(m_axis_tdata[fbn_pkg::RES_W-1:0]));
    end

    // All driving tasks start and end just after a falling edge, so every
    // input changes there and gets at most one update per time step.
    task automatic send_item(input logic [1:0] act, input logic [3:0] idx,
                             input logic [7:0] val);
        fbn_pkg::item_t it;
        int             gap;
        it.action     = act;
        it.reg_index  = idx;
        it.write_byte = val;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 16'(it);
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic tick();
        send_item(fbn_pkg::ACT_TICK, 4'($urandom), 8'($urandom));
    endtask

    // A tick, or now and then a read of any register, while waiting for the
    // device to finish something.
    task automatic tick_or_peek();
        if ($urandom_range(4) == 0)
            send_item(fbn_pkg::ACT_READ, 4'($urandom), 8'($urandom));
        else
            tick();
    endtask

    // Stops the sender and waits until every result has come back, then waits
    // further, as far as its argument asks, so the block is surely idle.
    task automatic drain(input int extra);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_cfg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Reads a configuration register back and compares it with the shadow.
    task automatic apb_check(input logic [1:0] idx);
        logic [63:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        if (got !== sb.cfg_value(idx))
            sb.flag($sformatf("config register %0d exp %h got %h",
                              idx, sb.cfg_value(idx), got));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [15:0] send_d, input logic [15:0] reply_d,
                             input logic [47:0] mac);
        drain(20);
        apb_write(fbn_pkg::CFG_SEND_DELAY, {48'h0, send_d});
        apb_write(fbn_pkg::CFG_REPLY_DELAY, {48'h0, reply_d});
        apb_write(fbn_pkg::CFG_SERVER_MAC, {16'h0, mac});
        apb_check(fbn_pkg::CFG_SEND_DELAY);
        apb_check(fbn_pkg::CFG_REPLY_DELAY);
        apb_check(fbn_pkg::CFG_SERVER_MAC);
    endtask

    // Writes a frame from offset zero of the transmit buffer. A well-formed
    // ARP request carries the type and operation bytes; otherwise one of
    // those four bytes is spoiled. The upper bits of the pointer high byte
    // are random since the device must drop them.
    task automatic load_frame(input bit is_request, input int len);
        logic [7:0] b;
        int         bad;
        int         j;
        bad = is_request ? -1 : $urandom_range(3);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_PTR_LO, 8'h00);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_PTR_HI, {5'($urandom), 3'b000});
        for (int i = 0; i < len; i++)
        begin
            j = -1;
            if (i == int'(fbn_pkg::OFS_TYPE_HI))
            begin
                b = fbn_pkg::ARP_TYPE_HI;
                j = 0;
            end
            else if (i == int'(fbn_pkg::OFS_TYPE_LO))
            begin
                b = fbn_pkg::ARP_TYPE_LO;
                j = 1;
            end
            else if (i == int'(fbn_pkg::OFS_OP_HI))
            begin
                b = fbn_pkg::ARP_OP_HI;
                j = 2;
            end
            else if (i == int'(fbn_pkg::OFS_OP_LO))
            begin
                b = fbn_pkg::ARP_OP_REQ_LO;
                j = 3;
            end
            else
            begin
                b = 8'($urandom);
            end
            if (j >= 0 && j == bad)
                b = b ^ 8'($urandom_range(1, 255));
            send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_DATA, b);
        end
    endtask

    task automatic take_rx();
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_RX_OWN, 8'($urandom) | 8'h01);
    endtask

    task automatic take_tx();
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_OWN, 8'($urandom) | 8'h01);
    endtask

    task automatic read_back_rx(input int n);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_RX_PTR_LO, 8'h00);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_RX_PTR_HI, {5'($urandom), 3'b000});
        repeat (n) send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_DATA, 8'($urandom));
    endtask

    // One full exchange: load a frame, send it, and most of the time hand
    // the receive buffer over and read the reply back. Skipping delivery
    // leaves the reply pending so that a later request overwrites it.
    task automatic arp_exchange(input bit is_request);
        int len;
        len = $urandom_range(44, 64);
        while (sb.tx_owned)
            tick();
        load_frame(is_request, len);
        if ($urandom_range(1))
            take_rx();
        take_tx();
        while (sb.tx_owned)
            tick_or_peek();
        if (sb.reply_pending && $urandom_range(9) < 7)
        begin
            if (!sb.rx_owned)
                take_rx();
            while (sb.rx_owned && sb.reply_pending)
                tick_or_peek();
            read_back_rx(len);
        end
    endtask

    task automatic noise(input int n);
        repeat (n) send_item(2'($urandom), 4'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int unsigned stop_at;
        int unsigned next_cfg_at;
        int          pick;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        items_sent    = 0;
        sb = new();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset values of the configuration registers. The buffer clearing
        // pass runs meanwhile; the first item simply waits for tready.
        apb_check(fbn_pkg::CFG_SEND_DELAY);
        apb_check(fbn_pkg::CFG_REPLY_DELAY);
        apb_check(fbn_pkg::CFG_SERVER_MAC);

        // Directed part: receive registers and transmit ownership at reset, pointer
        // masking and wrap-around, inert accesses, ownership requests with bit 0
        // clear or already held, and receive ownership held with nothing pending.
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_PTR_LO, 8'h00);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_PTR_HI, 8'hFF);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_DATA, 8'h00);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_OWN, 8'h00);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_TX_OWN, 8'h00);
        send_item(fbn_pkg::ACT_READ, REG_SPARE, 8'hFF);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_PTR_HI, 8'hFF);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_PTR_LO, 8'hFF);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_TX_PTR_HI, 8'h00);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_DATA, 8'hA5);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_TX_PTR_LO, 8'h00);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_PTR_HI, 8'h07);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_PTR_LO, 8'hFF);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_TX_DATA, 8'h00);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_TX_PTR_LO, 8'h00);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_TX_OWN, 8'hFE);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_RX_OWN, 8'h00);
        send_item(ACT_UNUSED, fbn_pkg::REG_RX_DATA, 8'hFF);
        send_item(fbn_pkg::ACT_WRITE, REG_SPARE, 8'hFF);
        send_item(fbn_pkg::ACT_TICK, fbn_pkg::REG_TX_OWN, 8'hFF);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_RX_OWN, 8'h01);
        send_item(fbn_pkg::ACT_TICK, fbn_pkg::REG_RX_OWN, 8'h00);
        send_item(fbn_pkg::ACT_WRITE, fbn_pkg::REG_RX_OWN, 8'hFF);
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_OWN, 8'h00);

        // Random part, split into phases with different settings. The first has
        // zero delays and MAC, the second small fixed delays and an all-ones MAC;
        // later ones pick small random delays so that frames go out often.
        configure(16'h0000, 16'h0000, 48'h0000_0000_0000);
        stop_at     = items_sent + RAND_ITEMS;
        next_cfg_at = items_sent + 180;
        pick        = 0;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_cfg_at)
            begin
                if (next_cfg_at == stop_at - RAND_ITEMS + 180)
                    configure(16'd5, 16'd3, 48'hFFFF_FFFF_FFFF);
                else
                    configure(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                              {16'($urandom), 32'($urandom)});
                next_cfg_at += 180;
            end
            quiet = ($urandom_range(3) == 0);
            pick  = $urandom_range(99);
            if (pick < 65)
                arp_exchange(pick < 52);
            else if (pick < 80)
                noise($urandom_range(10, 30));
            else if (pick < 92)
                read_back_rx($urandom_range(8, 48));
            else
                drain(1);
        end
        quiet = 1'b0;

        // A long send delay with a zero reply delay: any older reply is
        // delivered first, then a request goes out with receive owned, and
        // its reply must land in the same tick as the send.
        configure(16'd40, 16'h0000, {16'($urandom), 32'($urandom)});
        if (sb.reply_pending)
        begin
            if (!sb.rx_owned)
                take_rx();
            while (sb.rx_owned && sb.reply_pending)
                tick();
        end
        while (sb.tx_owned)
            tick();
        quiet = 1'b1;
        load_frame(1'b1, 44);
        take_rx();
        take_tx();
        while (sb.tx_owned)
            tick();
        quiet = 1'b0;
        read_back_rx(44);

        // Longest reply delay: the reply stays pending while receive is
        // owned and the countdown runs.
        configure(16'h0000, 16'hFFFF, {16'($urandom), 32'($urandom)});
        load_frame(1'b1, 48);
        take_rx();
        take_tx();
        repeat (30) tick_or_peek();
        send_item(fbn_pkg::ACT_READ, fbn_pkg::REG_RX_OWN, 8'($urandom));
        noise(20);

        drain(50);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
design/fbn_pkg.sv
design/fbn_ram.sv
design/fbn_cfg.sv
design/fbn_engine.sv
design/frame_buffer_nic_with_arp_reply_core.sv
tb/tb_frame_buffer_nic_with_arp_reply_core.sv
